// File: design/khnt_pkg.sv
// Shared types, widths and constants for the key hysteresis note trigger.
`timescale 1ns / 1ps

package khnt_pkg;

  localparam int KEYS_DEF = 64;

  localparam int IDX_W = 6;
  localparam int PCT_W = 7;
  localparam int CH_W  = 5;
  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ON_THR   = 3'd0;
  localparam logic [2:0] REG_OFF_THR  = 3'd1;
  localparam logic [2:0] REG_CHANNEL  = 3'd2;
  localparam logic [2:0] REG_BASE     = 3'd3;
  localparam logic [2:0] REG_LIMIT    = 3'd4;

  localparam logic [PCT_W-1:0]  ON_THR_RST  = 7'd60;
  localparam logic [PCT_W-1:0]  OFF_THR_RST = 7'd40;
  localparam logic [CH_W-1:0]   CHANNEL_RST = 5'd1;
  localparam logic [NOTE_W-1:0] BASE_RST    = 7'd36;
  localparam logic [6:0]        LIMIT_RST   = 7'd64;

  localparam logic [CH_W-1:0]   CH_MIN   = 5'd1;
  localparam logic [CH_W-1:0]   CH_MAX   = 5'd16;
  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
  localparam logic [VEL_W-1:0]  VEL_MIN  = 7'd1;
  localparam logic [VEL_W-1:0]  VEL_MAX  = 7'd127;

  // velocity = (s*127 + 50) / 100, divide by 100 as multiply by 5243 >> 19
  localparam int VEL_SCALE   = 127;
  localparam int VEL_ROUND   = 50;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic [PCT_W-1:0]  on_threshold;
    logic [PCT_W-1:0]  off_threshold;
    logic [CH_W-1:0]   voice_channel;
    logic [NOTE_W-1:0] note_base;
    logic [6:0]        key_limit;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic              is_note_on;
    logic [CH_W-1:0]   channel;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } evt_t;

endpackage

// File: design/khnt_eval.sv
// Per-sample decision: range check, hysteresis test and event field math.
`timescale 1ns / 1ps

module khnt_eval #(
  parameter int KEYS = khnt_pkg::KEYS_DEF
) (
  input  khnt_pkg::cfg_t                  cfg,
  input  logic [khnt_pkg::IDX_W-1:0]      key_index,
  input  logic [khnt_pkg::PCT_W-1:0]      strength,
  input  logic                            calibrating,
  input  logic                            held,
  output logic                            in_range,
  output khnt_pkg::evt_t                  evt
);
  import khnt_pkg::*;

  localparam logic [7:0] KEYS_B = 8'(KEYS);

  logic [7:0]  idx_ext;
  logic [7:0]  note_sum;
  logic [13:0] vel_num;
  logic [26:0] vel_prod;
  logic [7:0]  vel_q;
  logic [VEL_W-1:0] vel_on;
  logic [CH_W-1:0]  ch;
  logic sound;
  logic release_key;

  assign idx_ext  = 8'(key_index);
  assign in_range = !calibrating && (idx_ext < 8'(cfg.key_limit)) && (idx_ext < KEYS_B);

  assign sound       = in_range && !held && (strength >= cfg.on_threshold);
  assign release_key = in_range && held && (strength <= cfg.off_threshold);

  assign vel_num  = 14'(strength) * 14'(VEL_SCALE) + 14'(VEL_ROUND);
  assign vel_prod = 27'(vel_num) * 27'(RECIP_100);
  assign vel_q    = vel_prod[RECIP_SHIFT +: 8];

  always_comb begin
    if (vel_q < 8'(VEL_MIN)) begin
      vel_on = VEL_MIN;
    end else if (vel_q > 8'(VEL_MAX)) begin
      vel_on = VEL_MAX;
    end else begin
      vel_on = vel_q[VEL_W-1:0];
    end
  end

  always_comb begin
    if (cfg.voice_channel < CH_MIN) begin
      ch = CH_MIN;
    end else if (cfg.voice_channel > CH_MAX) begin
      ch = CH_MAX;
    end else begin
      ch = cfg.voice_channel;
    end
  end

  assign note_sum = 8'(cfg.note_base) + idx_ext;

  always_comb begin
    evt.fire       = sound || release_key;
    evt.is_note_on = sound;
    evt.channel    = ch;
    evt.note       = (note_sum > 8'(NOTE_MAX)) ? NOTE_MAX : note_sum[NOTE_W-1:0];
    evt.velocity   = sound ? vel_on : '0;
  end

endmodule

// File: design/key_hysteresis_note_trigger.sv
// Top level of the key hysteresis note trigger: channels, config and held bits.
//
// Input stream (s_*): one key sample per beat, key index and strength in
// s_tdata, the calibrating flag in s_tuser. Output stream (m_*): zero or one
// MIDI note event per sample, channel/note/velocity in m_tdata and the
// note-on flag in m_tuser. Config goes through the APB port, one register
// per word; write it only while the stream is idle.
// Pipeline: input register, then result register. Throughput: one sample per
// cycle while no event sample waits on a full result register; the held bit of a key
// is read and updated in the same cycle, so back-to-back samples of the same
// key see each other's effect.
// Reset clears all held bits, both pipeline valids and loads the register
// defaults. When the receiver stalls, the result register holds its beat;
// samples that produce no event keep flowing, and the input stage stops only
// when a sample with an event finds the result register still full.
`timescale 1ns / 1ps

module key_hysteresis_note_trigger #(
  parameter int KEYS = khnt_pkg::KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // key_index[5:0], strength[12:6], zeros
  input  logic                          s_tuser,   // calibrating
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // channel[4:0], note[11:5], velocity[18:12]
  output logic                          m_tuser,   // is_note_on
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [khnt_pkg::ADDR_W-1:0]   paddr,
  input  logic [khnt_pkg::DATA_W-1:0]   pwdata,
  output logic [khnt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import khnt_pkg::*;

  localparam int HIDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

  cfg_t cfg;
  logic [2:0] reg_idx;
  logic       wr_en;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [PCT_W-1:0]  s1_strength;
  logic              s1_cal;

  logic [KEYS-1:0]   held;
  logic [HIDX_W-1:0] hidx;
  logic              held_bit;
  logic              in_range;
  evt_t              evt;
  logic              out_free;
  logic              adv;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold  <= ON_THR_RST;
      cfg.off_threshold <= OFF_THR_RST;
      cfg.voice_channel <= CHANNEL_RST;
      cfg.note_base     <= BASE_RST;
      cfg.key_limit     <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ON_THR:  cfg.on_threshold  <= pwdata[PCT_W-1:0];
        REG_OFF_THR: cfg.off_threshold <= pwdata[PCT_W-1:0];
        REG_CHANNEL: cfg.voice_channel <= pwdata[CH_W-1:0];
        REG_BASE:    cfg.note_base     <= pwdata[NOTE_W-1:0];
        REG_LIMIT:   cfg.key_limit     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ON_THR:  prdata = DATA_W'(cfg.on_threshold);
      REG_OFF_THR: prdata = DATA_W'(cfg.off_threshold);
      REG_CHANNEL: prdata = DATA_W'(cfg.voice_channel);
      REG_BASE:    prdata = DATA_W'(cfg.note_base);
      REG_LIMIT:   prdata = DATA_W'(cfg.key_limit);
      default:     prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  assign out_free = !m_tvalid || m_tready;
  // a sample without an event never needs the result register
  assign adv      = s1_valid && (!evt.fire || out_free);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_idx      <= s_tdata[IDX_W-1:0];
      s1_strength <= s_tdata[IDX_W +: PCT_W];
      s1_cal      <= s_tuser;
    end
  end

  // ---------------- held bits and decision ----------------
  assign hidx     = HIDX_W'(s1_idx);
  assign held_bit = in_range ? held[hidx] : 1'b0;

  khnt_eval #(
    .KEYS(KEYS)
  ) u_eval (
    .cfg        (cfg),
    .key_index  (s1_idx),
    .strength   (s1_strength),
    .calibrating(s1_cal),
    .held       (held_bit),
    .in_range   (in_range),
    .evt        (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (adv && evt.fire) begin
      held[hidx] <= evt.is_note_on;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= adv && evt.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adv && evt.fire) begin
      m_tdata <= {5'b0, evt.velocity, evt.note, evt.channel};
      m_tuser <= evt.is_note_on;
    end
  end

endmodule
